/* src/first_fit_page_region_allocator_unit_assert.svh */
// assertion macros for the page region allocator
`ifndef FIRST_FIT_PAGE_REGION_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_PAGE_REGION_ALLOCATOR_UNIT_ASSERT_SVH

// assertion checked while out of reset
`define FPRA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion checked at every rising clock edge, also in reset
`define FPRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/fpra_pkg.sv */
// shared constants, types and codes of the page region allocator
package fpra_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned PageBytes    = 4096;
  localparam int unsigned AddrBits     = 32;

  localparam int unsigned IdxW     = $clog2(TableEntries);
  localparam int unsigned CntW     = $clog2(TableEntries + 1);
  localparam int unsigned PageOffW = $clog2(PageBytes);
  localparam int unsigned FieldW   = 32;
  localparam int unsigned PagesW   = 21;
  localparam int unsigned VpnW     = AddrBits - PageOffW;
  localparam int unsigned PageW    = ((VpnW > PagesW) ? VpnW : PagesW) + 1;
  localparam int unsigned EntryW   = PageW + PagesW;

  localparam logic [CntW-1:0] TableFull = CntW'(TableEntries);

  localparam logic CFG_POOL_BASE  = 1'b0;
  localparam logic CFG_POOL_PAGES = 1'b1;

  localparam logic [FieldW-1:0] PoolBaseRst  = 32'd4194304;
  localparam logic [PagesW-1:0] PoolPagesRst = 21'd1024;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_RELEASE,
    KIND_CHECK
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NO_FIT,
    STAT_FULL,
    STAT_NOT_FOUND
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_MOVE,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [PageW-1:0]  base;
    logic [PagesW-1:0] count;
  } entry_t;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] region_address;
    logic [PagesW-1:0] page_count;
    logic              legitimate;
  } result_t;

endpackage

/* src/fpra_if.sv */
// request and response channel interfaces
interface fpra_req_if
  import fpra_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [FieldW-1:0] size_bytes;
  logic [FieldW-1:0] address;

  modport source (output valid, kind, size_bytes, address, input ready);
  modport sink (input valid, kind, size_bytes, address, output ready);
endinterface

interface fpra_rsp_if
  import fpra_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [FieldW-1:0] region_address;
  logic [PagesW-1:0] page_count;
  logic              legitimate;

  modport source (output valid, status, region_address, page_count, legitimate,
                  input ready);
  modport sink (input valid, status, region_address, page_count, legitimate,
                output ready);
endinterface

/* src/fpra_ram.sv */
// generic single write port, single read port ram with registered read
module fpra_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/first_fit_page_region_allocator_unit.sv */
// top level: first fit page region allocator over two region tables
// an early answer goes from the idle state through the done state to the response register;
// else the scan reads one table entry a cycle through the table ram read port, up to 256 entries
// one item at a time: no new request is taken until the response register is loaded
// reset and every configuration write go through the init state, which rewrites entry 0 of both
// tables; no request is taken in that state
module first_fit_page_region_allocator_unit
  import fpra_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [FieldW-1:0] cfg_data_i,
  fpra_req_if.sink          req_i,
  fpra_rsp_if.source        rsp_o
);

  `include "first_fit_page_region_allocator_unit_assert.svh"

  fsm_e              state_q, state_d;
  logic [FieldW-1:0] pool_base_q;
  logic [PagesW-1:0] pool_pages_q;
  logic [CntW-1:0]   used_n_q, used_n_d;
  logic [CntW-1:0]   free_n_q, free_n_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic              rvld_q, rvld_d;
  logic [IdxW-1:0]   ridx_q, ridx_d;
  logic [IdxW-1:0]   hit_idx_q, hit_idx_d;
  kind_e             kind_q, kind_d;
  logic [PagesW-1:0] need_q, need_d;
  logic [FieldW-1:0] addr_q, addr_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic              used_we, free_we;
  logic [IdxW-1:0]   used_waddr, free_waddr, used_raddr, free_raddr;
  entry_t            used_wdata, free_wdata, used_rdata, free_rdata, rd;
  logic [PageW-1:0]  first_page;
  logic [PagesW-1:0] req_need;
  logic [PageW:0]    ap_ext, rd_end;
  logic [CntW-1:0]   lim;
  logic              hit;

  fpra_ram #(.Depth(TableEntries), .Width(EntryW)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (used_raddr),
    .rdata_o (used_rdata)
  );

  fpra_ram #(.Depth(TableEntries), .Width(EntryW)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

  assign first_page = PageW'(pool_base_q[AddrBits-1:PageOffW]);
  assign req_need   = PagesW'(req_i.size_bytes[FieldW-1:PageOffW])
                    + PagesW'(|req_i.size_bytes[PageOffW-1:0]);

  // scan compare on the entry returned by the ram
  assign rd     = (kind_q == KIND_ALLOC) ? free_rdata : used_rdata;
  assign ap_ext = (PageW + 1)'(addr_q[AddrBits-1:PageOffW]);
  assign rd_end = (PageW + 1)'(rd.base) + (PageW + 1)'(rd.count);
  assign lim    = (kind_q == KIND_ALLOC) ? free_n_q : used_n_q;

  always_comb begin
    case (kind_q)
      KIND_ALLOC:   hit = (rd.count >= need_q);
      KIND_RELEASE: hit = (rd.base[PageW-1:VpnW] == '0)
                       && (rd.base[VpnW-1:0] == addr_q[AddrBits-1:PageOffW])
                       && (addr_q[PageOffW-1:0] == '0);
      KIND_CHECK:   hit = ((PageW + 1)'(rd.base) <= ap_ext) && (ap_ext < rd_end);
      default:      hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    used_n_d   = used_n_q;
    free_n_d   = free_n_q;
    scan_d     = scan_q;
    rvld_d     = 1'b0;
    ridx_d     = ridx_q;
    hit_idx_d  = hit_idx_q;
    kind_d     = kind_q;
    need_d     = need_q;
    addr_d     = addr_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    used_we    = 1'b0;
    free_we    = 1'b0;
    used_waddr = '0;
    free_waddr = '0;
    used_wdata = '0;
    free_wdata = '0;
    used_raddr = scan_q[IdxW-1:0];
    free_raddr = scan_q[IdxW-1:0];
    req_i.ready = (state_q == S_IDLE);

    case (state_q)
      S_INIT: begin
        used_we    = 1'b1;
        used_wdata = '{base: first_page, count: PagesW'(1)};
        free_we    = 1'b1;
        free_wdata = '{base: first_page + PageW'(1), count: pool_pages_q - PagesW'(1)};
        used_n_d   = CntW'(1);
        free_n_d   = (pool_pages_q > PagesW'(1)) ? CntW'(1) : '0;
        state_d    = S_IDLE;
      end
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d = kind_e'(req_i.kind);
          need_d = req_need;
          addr_d = req_i.address;
          res_d  = '0;
          scan_d = '0;
          state_d = S_SCAN;
          case (req_i.kind)
            KIND_ALLOC: begin
              if (used_n_q >= TableFull) begin
                res_d.status = STAT_FULL;
                state_d = S_DONE;
              end else begin
                res_d.status = STAT_NO_FIT;
                if (req_need == '0) begin
                  state_d = S_DONE;
                end
              end
            end
            KIND_RELEASE: begin
              if (free_n_q >= TableFull) begin
                res_d.status = STAT_FULL;
                state_d = S_DONE;
              end else begin
                res_d.status = STAT_NOT_FOUND;
              end
            end
            KIND_CHECK: begin
              if (req_i.address[AddrBits-1:PageOffW] == pool_base_q[AddrBits-1:PageOffW]) begin
                res_d.legitimate = 1'b1;
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rvld_q && hit) begin
          hit_idx_d = ridx_q;
          state_d   = S_DONE;
          case (kind_q)
            KIND_ALLOC: begin
              used_we    = 1'b1;
              used_waddr = used_n_q[IdxW-1:0];
              used_wdata = '{base: rd.base, count: need_q};
              used_n_d   = used_n_q + CntW'(1);
              res_d.status         = STAT_OK;
              res_d.region_address = {rd.base[VpnW-1:0], {PageOffW{1'b0}}};
              res_d.page_count     = need_q;
              if (rd.count == need_q) begin
                free_n_d = free_n_q - CntW'(1);
                state_d  = S_FETCH;
              end else begin
                free_we    = 1'b1;
                free_waddr = ridx_q;
                free_wdata = '{base: rd.base + PageW'(need_q), count: rd.count - need_q};
              end
            end
            KIND_RELEASE: begin
              free_we    = 1'b1;
              free_waddr = free_n_q[IdxW-1:0];
              free_wdata = rd;
              free_n_d   = free_n_q + CntW'(1);
              used_n_d   = used_n_q - CntW'(1);
              res_d.status         = STAT_OK;
              res_d.region_address = addr_q;
              res_d.page_count     = rd.count;
              state_d = S_FETCH;
            end
            default: begin
              res_d.legitimate = 1'b1;
            end
          endcase
        end else if (scan_q < lim) begin
          rvld_d = 1'b1;
          ridx_d = scan_q[IdxW-1:0];
          scan_d = scan_q + CntW'(1);
        end else if (!rvld_q) begin
          state_d = S_DONE;
        end
      end
      S_FETCH: begin
        // last entry moves into the hole
        used_raddr = used_n_q[IdxW-1:0];
        free_raddr = free_n_q[IdxW-1:0];
        state_d    = S_MOVE;
      end
      S_MOVE: begin
        if (kind_q == KIND_ALLOC) begin
          free_we    = 1'b1;
          free_waddr = hit_idx_q;
          free_wdata = free_rdata;
        end else begin
          used_we    = 1'b1;
          used_waddr = hit_idx_q;
          used_wdata = used_rdata;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase

    if (cfg_we_i) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      pool_base_q  <= PoolBaseRst;
      pool_pages_q <= PoolPagesRst;
      used_n_q     <= CntW'(1);
      free_n_q     <= CntW'(1);
      scan_q       <= '0;
      rvld_q       <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_n_q  <= used_n_d;
      free_n_q  <= free_n_d;
      scan_q    <= scan_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POOL_BASE:  pool_base_q  <= cfg_data_i;
          CFG_POOL_PAGES: pool_pages_q <= cfg_data_i[PagesW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q    <= ridx_d;
    hit_idx_q <= hit_idx_d;
    kind_q    <= kind_d;
    need_q    <= need_d;
    addr_q    <= addr_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.region_address = out_q.region_address;
  assign rsp_o.page_count     = out_q.page_count;
  assign rsp_o.legitimate     = out_q.legitimate;

  `FPRA_ASSERT(a_counts_bounded, clk_i, rst_ni, (used_n_q <= TableFull) && (free_n_q <= TableFull), "region table count out of range")
  `FPRA_ASSERT(a_scan_read_only, clk_i, rst_ni, (state_q == S_SCAN && !(rvld_q && hit)) |-> (!used_we && !free_we), "table written during a scan")
  `FPRA_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q == S_DONE), "response loaded outside the done state")
  `FPRA_ASSERT(a_move_after_fetch, clk_i, rst_ni, (state_q == S_MOVE) |-> $past(state_q == S_FETCH), "entry move without a fetch")

endmodule
